// ===== rtl/tekd_pkg.sv =====
`default_nettype none

package tekd_pkg;

  // special bytes of the terminal stream
  localparam logic [7:0] ByteEsc   = 8'h1B;
  localparam logic [7:0] ByteDel   = 8'h7F;
  localparam logic [7:0] ByteBs    = 8'h08;
  localparam logic [7:0] ByteSs3   = 8'h4F;  // 'O'
  localparam logic [7:0] ByteCsi   = 8'h5B;  // '['
  localparam logic [7:0] ByteTilde = 8'h7E;
  localparam logic [7:0] ByteSemi  = 8'h3B;
  localparam logic [7:0] ByteOne   = 8'h31;
  localparam logic [7:0] ByteThree = 8'h33;
  localparam logic [7:0] ByteFive  = 8'h35;
  localparam logic [7:0] ByteEight = 8'h38;
  localparam logic [7:0] ByteUpC   = 8'h43;  // 'C'
  localparam logic [7:0] ByteUpD   = 8'h44;  // 'D'

  // result queue: one byte makes at most two results
  localparam int unsigned ResDepth = 3;
  localparam int unsigned CntW     = 2;
  localparam int unsigned NumW     = 4;

  typedef enum logic [4:0] {
    KEY_PLAIN      = 5'd0,
    KEY_ESC        = 5'd1,
    KEY_UP         = 5'd2,
    KEY_DOWN       = 5'd3,
    KEY_RIGHT      = 5'd4,
    KEY_LEFT       = 5'd5,
    KEY_HOME       = 5'd6,
    KEY_END        = 5'd7,
    KEY_INSERT     = 5'd8,
    KEY_DELETE     = 5'd9,
    KEY_PGUP       = 5'd10,
    KEY_PGDN       = 5'd11,
    KEY_ALT_BKSP   = 5'd12,
    KEY_ALT_D      = 5'd13,
    KEY_ALT_RIGHT  = 5'd14,
    KEY_ALT_LEFT   = 5'd15,
    KEY_CTRL_RIGHT = 5'd16,
    KEY_CTRL_LEFT  = 5'd17
  } key_e;

  // how far into a sequence the decoder is
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_SS3,
    ST_CSI,
    ST_CSI_NUM,
    ST_CSI_SEMI,
    ST_CSI_MOD5,
    ST_CSI_MOD3
  } state_e;

  typedef enum logic [1:0] {
    M_NONE,
    M_PREFIX,
    M_DONE
  } match_e;

  typedef struct packed {
    key_e       key;
    logic [7:0] chr;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } dec_out_t;

  // single byte after esc
  function automatic key_e alt_key(input logic [7:0] b);
    key_e k;
    unique case (b)
      ByteDel, ByteBs: k = KEY_ALT_BKSP;
      8'h64:           k = KEY_ALT_D;      // 'd'
      8'h66:           k = KEY_ALT_RIGHT;  // 'f'
      8'h62:           k = KEY_ALT_LEFT;   // 'b'
      default:         k = KEY_PLAIN;
    endcase
    return k;
  endfunction

  // final letter after 'O' or '['
  function automatic key_e arrow_key(input logic [7:0] b);
    key_e k;
    unique case (b)
      8'h41:   k = KEY_UP;
      8'h42:   k = KEY_DOWN;
      8'h43:   k = KEY_RIGHT;
      8'h44:   k = KEY_LEFT;
      8'h48:   k = KEY_HOME;
      8'h46:   k = KEY_END;
      default: k = KEY_PLAIN;
    endcase
    return k;
  endfunction

  // '[' digit '~' forms, digit given as its low nibble
  function automatic key_e tilde_key(input logic [NumW-1:0] n);
    key_e k;
    unique case (n)
      4'd1, 4'd7: k = KEY_HOME;
      4'd2:       k = KEY_INSERT;
      4'd3:       k = KEY_DELETE;
      4'd4, 4'd8: k = KEY_END;
      4'd5:       k = KEY_PGUP;
      4'd6:       k = KEY_PGDN;
      default:    k = KEY_PLAIN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tekd_decode.sv =====
`default_nettype none

module tekd_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  output tekd_pkg::dec_out_t      dec_o
);

  tekd_pkg::state_e                 state_q, state_d;
  logic [tekd_pkg::NumW-1:0]        num_q, num_d;

  tekd_pkg::match_e                 match;
  tekd_pkg::key_e                   hit;
  tekd_pkg::state_e                 pfx_state;
  logic [tekd_pkg::NumW-1:0]        pfx_num;

  // match the byte against the sequences that are still open
  always_comb begin
    match     = tekd_pkg::M_NONE;
    hit       = tekd_pkg::KEY_PLAIN;
    pfx_state = tekd_pkg::ST_IDLE;
    pfx_num   = num_q;
    unique case (state_q)
      tekd_pkg::ST_IDLE: begin
        match = tekd_pkg::M_NONE;
      end
      tekd_pkg::ST_ESC: begin
        hit = tekd_pkg::alt_key(byte_i);
        priority if (hit != tekd_pkg::KEY_PLAIN) begin
          match = tekd_pkg::M_DONE;
        end else if (byte_i == tekd_pkg::ByteSs3) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_SS3;
        end else if (byte_i == tekd_pkg::ByteCsi) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_CSI;
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
      tekd_pkg::ST_SS3: begin
        hit = tekd_pkg::arrow_key(byte_i);
        if (hit != tekd_pkg::KEY_PLAIN) begin
          match = tekd_pkg::M_DONE;
        end
      end
      tekd_pkg::ST_CSI: begin
        hit = tekd_pkg::arrow_key(byte_i);
        priority if (hit != tekd_pkg::KEY_PLAIN) begin
          match = tekd_pkg::M_DONE;
        end else if (byte_i >= tekd_pkg::ByteOne && byte_i <= tekd_pkg::ByteEight) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_CSI_NUM;
          pfx_num   = byte_i[tekd_pkg::NumW-1:0];
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
      tekd_pkg::ST_CSI_NUM: begin
        priority if (byte_i == tekd_pkg::ByteTilde) begin
          match = tekd_pkg::M_DONE;
          hit   = tekd_pkg::tilde_key(num_q);
        end else if (num_q == tekd_pkg::NumW'(1) && byte_i == tekd_pkg::ByteSemi) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_CSI_SEMI;
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
      tekd_pkg::ST_CSI_SEMI: begin
        priority if (byte_i == tekd_pkg::ByteFive) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_CSI_MOD5;
        end else if (byte_i == tekd_pkg::ByteThree) begin
          match     = tekd_pkg::M_PREFIX;
          pfx_state = tekd_pkg::ST_CSI_MOD3;
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
      tekd_pkg::ST_CSI_MOD5: begin
        priority if (byte_i == tekd_pkg::ByteUpC) begin
          match = tekd_pkg::M_DONE;
          hit   = tekd_pkg::KEY_CTRL_RIGHT;
        end else if (byte_i == tekd_pkg::ByteUpD) begin
          match = tekd_pkg::M_DONE;
          hit   = tekd_pkg::KEY_CTRL_LEFT;
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
      tekd_pkg::ST_CSI_MOD3: begin
        priority if (byte_i == tekd_pkg::ByteUpC) begin
          match = tekd_pkg::M_DONE;
          hit   = tekd_pkg::KEY_ALT_RIGHT;
        end else if (byte_i == tekd_pkg::ByteUpD) begin
          match = tekd_pkg::M_DONE;
          hit   = tekd_pkg::KEY_ALT_LEFT;
        end else begin
          match = tekd_pkg::M_NONE;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    if (accept_i) begin
      if (state_q == tekd_pkg::ST_IDLE) begin
        if (byte_i == tekd_pkg::ByteEsc) begin
          state_d = tekd_pkg::ST_ESC;
        end
      end else begin
        unique case (match)
          tekd_pkg::M_DONE: begin
            state_d = tekd_pkg::ST_IDLE;
          end
          tekd_pkg::M_PREFIX: begin
            state_d = pfx_state;
            num_d   = pfx_num;
          end
          default: begin
            // esc right after esc keeps an escape pending
            if (state_q == tekd_pkg::ST_ESC && byte_i == tekd_pkg::ByteEsc) begin
              state_d = tekd_pkg::ST_ESC;
            end else begin
              state_d = tekd_pkg::ST_IDLE;
            end
          end
        endcase
      end
    end
  end

  // results of this byte
  always_comb begin
    dec_o = '0;
    dec_o.res0.key = tekd_pkg::KEY_PLAIN;
    dec_o.res1.key = tekd_pkg::KEY_PLAIN;
    if (accept_i) begin
      if (state_q == tekd_pkg::ST_IDLE) begin
        dec_o.push0     = (byte_i != tekd_pkg::ByteEsc);
        dec_o.res0.chr  = byte_i;
        dec_o.res0.last = 1'b1;
      end else begin
        unique case (match)
          tekd_pkg::M_DONE: begin
            dec_o.push0     = 1'b1;
            dec_o.res0.key  = hit;
            dec_o.res0.last = 1'b1;
          end
          tekd_pkg::M_PREFIX: begin
            dec_o.push0 = 1'b0;
          end
          default: begin
            // unknown first byte: lone esc, then the byte afresh;
            // longer unknown sequences vanish
            if (state_q == tekd_pkg::ST_ESC) begin
              dec_o.push0     = 1'b1;
              dec_o.res0.key  = tekd_pkg::KEY_ESC;
              dec_o.res0.last = (byte_i == tekd_pkg::ByteEsc);
              dec_o.push1     = (byte_i != tekd_pkg::ByteEsc);
              dec_o.res1.chr  = byte_i;
              dec_o.res1.last = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tekd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

endmodule

`default_nettype wire

// ===== rtl/tekd_res_fifo.sv =====
`default_nettype none

module tekd_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tekd_pkg::dec_out_t dec_i,
  input  wire logic               pop_i,
  output tekd_pkg::result_t       head_o,
  output logic                    valid_o,
  output logic                    busy_o
);

  tekd_pkg::result_t              ent_q [tekd_pkg::ResDepth];
  tekd_pkg::result_t              ent_d [tekd_pkg::ResDepth];
  logic [tekd_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [tekd_pkg::CntW-1:0]      base;

  // shift out the head, then append new results behind what is left
  always_comb begin
    base = cnt_q - tekd_pkg::CntW'(pop_i);
    for (int i = 0; i < tekd_pkg::ResDepth; i++) begin
      if (pop_i && i < tekd_pkg::ResDepth - 1) begin
        ent_d[i] = ent_q[i+1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (dec_i.push0 && base == tekd_pkg::CntW'(i)) begin
        ent_d[i] = dec_i.res0;
      end
      if (dec_i.push1 && base + tekd_pkg::CntW'(1) == tekd_pkg::CntW'(i)) begin
        ent_d[i] = dec_i.res1;
      end
    end
    cnt_d = base + tekd_pkg::CntW'(dec_i.push0) + tekd_pkg::CntW'(dec_i.push1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o  = ent_q[0];
  assign valid_o = (cnt_q != '0);
  // room for two more results only while at most one is queued
  assign busy_o  = (cnt_q > tekd_pkg::CntW'(1));

endmodule

`default_nettype wire

// ===== rtl/terminal_escape_key_decoder.sv =====
// output: each result is registered into the result queue, whose head drives the ports
// throughput: one byte per cycle while the queue is not busy; a byte that makes two
//   results (lone esc then the byte itself) holds input off until the queue drains
// rate set by the three-entry result queue, which takes bytes while it holds <= 1
// reset: rst_ni async active low, decoder back to idle and result queue empty
`default_nettype none

module terminal_escape_key_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte beats in
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  // key event beats out
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [4:0]      key_code_o,
  output logic [7:0]      char_value_o,
  output logic            last_of_run_o
);

  logic                 in_acc;
  logic                 out_pop;
  logic                 q_busy;
  tekd_pkg::dec_out_t   dec;
  tekd_pkg::result_t    head;

  // the queue always has room for a two-result byte when it is not busy,
  // so input stall comes straight from a register
  assign in_stall_o = q_busy;
  assign in_acc     = in_valid_i & ~q_busy;
  assign out_pop    = out_valid_o & ~out_stall_i;

  // sequence tracker: decides this byte's results in the accept cycle
  tekd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_byte_i),
    .dec_o    (dec)
  );

  // results wait here until taken, head entry drives the ports
  tekd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dec_i   (dec),
    .pop_i   (out_pop),
    .head_o  (head),
    .valid_o (out_valid_o),
    .busy_o  (q_busy)
  );

  assign key_code_o    = head.key;
  assign char_value_o  = head.chr;
  assign last_of_run_o = head.last;

endmodule

`default_nettype wire

// ===== rtl/tekd_checker.sv =====
`default_nettype none

module tekd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [4:0] key_code_o,
  input wire logic [7:0] char_value_o,
  input wire logic       last_of_run_o
);

  // a held beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_code_o)
      && $stable(char_value_o) && $stable(last_of_run_o))
    else $error("output beat changed while stalled");

  // named keys and lone esc carry no character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_code_o != 5'(tekd_pkg::KEY_PLAIN) |-> char_value_o == 8'd0)
    else $error("character on a non-plain key");

  // only the lone esc of a two-result byte may be a non-final beat
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> key_code_o == 5'(tekd_pkg::KEY_ESC))
    else $error("non-final beat that is not a lone esc");

  // an empty result side never holds off input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

  // with nothing queued and no byte taken, no result shows up
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result beat appeared without an input beat");

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (.*);

`default_nettype wire
